// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/cvci_pkg.sv =====
// Package: widths, lookup table, codes and helpers for the capacity lookup
`timescale 1ns / 1ps
package cvci_pkg;

    localparam int PACK_W = 21;
    localparam int CELLS_W = 8;
    localparam int CAP_W = 16;
    localparam int STAT_W = 2;
    localparam int CELL_W = 13;

    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES = PACK_W / DIV_BITS_PER_STAGE;

    localparam int TABLE_STORED = 15;
    localparam int TABLE_ENTRIES_DEF = 15;
    localparam int IDX_W = $clog2(TABLE_STORED);

    localparam logic [CELL_W-1:0] TBL_MV [TABLE_STORED] = '{
        13'd2800, 13'd2900, 13'd3000, 13'd3100, 13'd3200, 13'd3300, 13'd3400, 13'd3500,
        13'd3600, 13'd3700, 13'd3800, 13'd3900, 13'd4000, 13'd4100, 13'd4200
    };
    localparam logic [CAP_W-1:0] TBL_MAH [TABLE_STORED] = '{
        16'd50000, 16'd49600, 16'd48000, 16'd47000, 16'd45000, 16'd43400, 16'd40400,
        16'd36000, 16'd32000, 16'd25400, 16'd18200, 16'd14200, 16'd8000, 16'd3600, 16'd0
    };

    // table points are evenly spaced
    localparam int SPAN_MV = 100;
    localparam int OFF_W = $clog2(SPAN_MV);
    localparam int MAG_W = OFF_W + CAP_W;

    // divide by SPAN_MV as multiply by reciprocal, exact for MAG_W-bit operands
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W = 24;
    localparam longint RECIP_L = ((64'd1 << RECIP_SHIFT) + SPAN_MV - 1) / SPAN_MV;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

    localparam logic [STAT_W-1:0] ST_BELOW = 2'd0;
    localparam logic [STAT_W-1:0] ST_INSIDE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABOVE = 2'd2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_CELLS = 1'b0;
    localparam logic REG_RATED = 1'b1;

    localparam logic [CELLS_W-1:0] CELLS_RST = 8'd1;
    localparam logic [CAP_W-1:0] RATED_RST = 16'd50000;

    typedef struct packed {
        logic [CELLS_W-1:0] divisor;
        logic [CAP_W-1:0]   rated;
    } t_cfg;

    typedef struct packed {
        logic [CELLS_W-1:0] rem;
        logic [PACK_W-1:0]  dq;
    } t_div_st;

    // restoring division, DIV_BITS_PER_STAGE quotient bits
    function automatic t_div_st div_step(t_div_st s, logic [CELLS_W-1:0] d);
        t_div_st         r;
        logic [CELLS_W:0] t;
        r = s;
        for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            t = {r.rem, r.dq[PACK_W-1]};
            if (t >= {1'b0, d}) begin
                r.rem = CELLS_W'(t - {1'b0, d});
                r.dq  = {r.dq[PACK_W-2:0], 1'b1};
            end else begin
                r.rem = t[CELLS_W-1:0];
                r.dq  = {r.dq[PACK_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/cvci_if.sv =====
// Stream interfaces for pack voltage in and capacity out
`timescale 1ns / 1ps
interface cvci_in_if import cvci_pkg::*;;
    logic              valid;
    logic              ready;
    logic [PACK_W-1:0] pack_voltage_mv;

    modport source (output valid, output pack_voltage_mv, input ready);
    modport sink (input valid, input pack_voltage_mv, output ready);
endinterface

interface cvci_out_if import cvci_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CAP_W-1:0]  capacity_mah;
    logic [STAT_W-1:0] range_status;

    modport source (output valid, output capacity_mah, output range_status, input ready);
    modport sink (input valid, input capacity_mah, input range_status, output ready);
endinterface

// ===== sv/cvci_apb.sv =====
// APB configuration registers
`timescale 1ns / 1ps
module cvci_apb import cvci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [CELLS_W-1:0] r_cells;
    logic [CAP_W-1:0]   r_rated;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= CELLS_RST;
            r_rated <= RATED_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_CELLS: r_cells <= pwdata[CELLS_W-1:0];
                REG_RATED: r_rated <= pwdata[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CELLS: prdata = APB_DW'(r_cells);
            REG_RATED: prdata = APB_DW'(r_rated);
            default:   prdata = '0;
        endcase
    end

    // zero cells divides as one
    assign o_cfg.divisor = (r_cells == '0) ? CELLS_W'(1) : r_cells;
    assign o_cfg.rated = r_rated;

endmodule

// ===== sv/cvci_div.sv =====
// Pipelined restoring divider: pack voltage over series cell count
`timescale 1ns / 1ps
module cvci_div import cvci_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CELLS_W-1:0] i_divisor,
    cvci_in_if.sink            i_in,
    output logic               o_valid,
    output logic [PACK_W-1:0]  o_quot,
    input  logic               i_ready
);

    logic [DIV_STAGES-1:0] r_v;
    t_div_st               r_st [DIV_STAGES];
    logic [DIV_STAGES-1:0] w_rdy;
    logic [DIV_STAGES-1:0] w_src_v;
    t_div_st               w_nxt [DIV_STAGES];

    always_comb begin
        w_rdy[DIV_STAGES-1] = !r_v[DIV_STAGES-1] || i_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            t_div_st w_src;
            assign w_src.rem = '0;
            assign w_src.dq = i_in.pack_voltage_mv;
            assign w_src_v[g] = i_in.valid;
            assign w_nxt[g] = div_step(w_src, i_divisor);
        end else begin : g_rest
            assign w_src_v[g] = r_v[g-1];
            assign w_nxt[g] = div_step(r_st[g-1], i_divisor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_src_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_st[k] <= w_nxt[k];
            end
        end
    end

    assign i_in.ready = w_rdy[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot = r_st[DIV_STAGES-1].dq;

endmodule

// ===== sv/cvci_interp.sv =====
// Table search and linear interpolation pipeline
`timescale 1ns / 1ps
module cvci_interp import cvci_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CAP_W-1:0]  i_rated,
    input  logic              i_valid,
    input  logic [PACK_W-1:0] i_quot,
    output logic              o_ready,
    cvci_out_if.source        o_res
);

    localparam int N_USE = (TABLE_ENTRIES < TABLE_STORED) ? TABLE_ENTRIES : TABLE_STORED;
    localparam int N_CMP = N_USE - 1;
    localparam int PROD_W = MAG_W + RECIP_W;

    // stage valids: a compare, b select, c multiply, d reciprocal, e output
    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic w_ra, w_rb, w_rc, w_rd, w_re;

    logic [N_CMP-1:0]  r_a_lt;
    logic [CELL_W-1:0] r_a_cell;

    logic [STAT_W-1:0] r_b_status, n_b_status;
    logic [OFF_W-1:0]  r_b_off, n_b_off;
    logic [CAP_W-1:0]  r_b_mag, n_b_mag;
    logic              r_b_neg, n_b_neg;
    logic [CAP_W-1:0]  r_b_lo_mah, n_b_lo_mah;

    logic [STAT_W-1:0] r_c_status;
    logic [MAG_W-1:0]  r_c_mag;
    logic              r_c_neg;
    logic [CAP_W-1:0]  r_c_lo_mah;

    logic [STAT_W-1:0] r_d_status;
    logic [CAP_W-1:0]  r_d_q;
    logic              r_d_neg;
    logic [CAP_W-1:0]  r_d_lo_mah;

    logic [STAT_W-1:0] r_e_status;
    logic [CAP_W-1:0]  r_e_cap, n_e_cap;

    logic [N_CMP-1:0]  n_a_lt;
    logic [IDX_W-1:0]  w_idx, w_lo;
    logic              w_found;
    logic signed [CAP_W:0] w_dmah;
    logic [PROD_W-1:0] w_prod;

    assign w_re = !r_ve || o_res.ready;
    assign w_rd = !r_vd || w_re;
    assign w_rc = !r_vc || w_rd;
    assign w_rb = !r_vb || w_rc;
    assign w_ra = !r_va || w_rb;
    assign o_ready = w_ra;

    always_comb begin
        for (int j = 0; j < N_CMP; j++) begin
            n_a_lt[j] = i_quot < PACK_W'(TBL_MV[j]);
        end
    end

    // first point above the cell voltage
    always_comb begin
        w_idx = '0;
        w_found = 1'b0;
        for (int j = N_CMP - 1; j >= 0; j--) begin
            if (r_a_lt[j]) begin
                w_idx = IDX_W'(j);
                w_found = 1'b1;
            end
        end
        w_lo = (w_idx == '0) ? '0 : IDX_W'(w_idx - IDX_W'(1));
        if (!w_found) begin
            n_b_status = ST_ABOVE;
        end else if (w_idx == '0) begin
            n_b_status = ST_BELOW;
        end else begin
            n_b_status = ST_INSIDE;
        end
        n_b_off = OFF_W'(r_a_cell - TBL_MV[w_lo]);
        w_dmah = $signed({1'b0, TBL_MAH[w_idx]}) - $signed({1'b0, TBL_MAH[w_lo]});
        n_b_neg = w_dmah < 0;
        n_b_mag = n_b_neg ? CAP_W'(-w_dmah) : CAP_W'(w_dmah);
        n_b_lo_mah = TBL_MAH[w_lo];
    end

    assign w_prod = PROD_W'(r_c_mag) * PROD_W'(RECIP);

    always_comb begin
        case (r_d_status)
            ST_BELOW:  n_e_cap = i_rated;
            ST_INSIDE: n_e_cap = r_d_neg ? CAP_W'(r_d_lo_mah - r_d_q)
                                         : CAP_W'(r_d_lo_mah + r_d_q);
            default:   n_e_cap = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (w_ra) r_va <= i_valid;
            if (w_rb) r_vb <= r_va;
            if (w_rc) r_vc <= r_vb;
            if (w_rd) r_vd <= r_vc;
            if (w_re) r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ra) begin
            r_a_lt   <= n_a_lt;
            r_a_cell <= i_quot[CELL_W-1:0];
        end
        if (w_rb) begin
            r_b_status <= n_b_status;
            r_b_off    <= n_b_off;
            r_b_mag    <= n_b_mag;
            r_b_neg    <= n_b_neg;
            r_b_lo_mah <= n_b_lo_mah;
        end
        if (w_rc) begin
            r_c_status <= r_b_status;
            r_c_mag    <= MAG_W'(r_b_off) * MAG_W'(r_b_mag);
            r_c_neg    <= r_b_neg;
            r_c_lo_mah <= r_b_lo_mah;
        end
        if (w_rd) begin
            r_d_status <= r_c_status;
            r_d_q      <= w_prod[RECIP_SHIFT +: CAP_W];
            r_d_neg    <= r_c_neg;
            r_d_lo_mah <= r_c_lo_mah;
        end
        if (w_re) begin
            r_e_status <= r_d_status;
            r_e_cap    <= n_e_cap;
        end
    end

    assign o_res.valid = r_ve;
    assign o_res.capacity_mah = r_e_cap;
    assign o_res.range_status = r_e_status;

endmodule

// ===== sv/cell_voltage_to_capacity_interp.sv =====
// Top level: pack voltage to discharged capacity by table interpolation
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one pack voltage transfer per clock while the output is not stalled and returns
// one capacity transfer for each, in order: 7 divider stages (three quotient bits each)
// split the pack voltage over the series cell count, then 5 stages search the 15-point
// table, pick the segment, multiply, scale by the point spacing and register the result.
// Bubbles collapse and a stalled output holds the pipe without loss. Capacity is the
// rated value below the table (status 0), interpolated inside it (status 1), and 0 at
// or above the last point but one (status 2). Write the registers over APB only while
// no transfer is in flight.
module cell_voltage_to_capacity_interp import cvci_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    cvci_in_if.sink           i_in,
    cvci_out_if.source        o_res
);

    t_cfg              w_cfg;
    logic              w_div_valid;
    logic [PACK_W-1:0] w_quot;
    logic              w_int_ready;
    logic              w_res_above;
    logic              w_div_wait;

    cvci_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cvci_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (w_cfg.divisor),
        .i_in      (i_in),
        .o_valid   (w_div_valid),
        .o_quot    (w_quot),
        .i_ready   (w_int_ready)
    );

    cvci_interp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rated (w_cfg.rated),
        .i_valid (w_div_valid),
        .i_quot  (w_quot),
        .o_ready (w_int_ready),
        .o_res   (o_res)
    );

    assign w_res_above = o_res.valid && (o_res.range_status == ST_ABOVE);
    assign w_div_wait = w_div_valid && !w_int_ready;

    `ASSERT_RST(a_above_zero, w_res_above |-> (o_res.capacity_mah == '0), "above-top capacity nonzero")
    `ASSERT_RST(a_stall_src, !w_int_ready |-> (o_res.valid && !o_res.ready), "unexpected stall")
    `ASSERT_RST(a_div_hold, w_div_wait |=> (w_div_valid && $stable(w_quot)), "divider result lost")

endmodule

// ===== tb/cell_voltage_to_capacity_interp_tb.sv =====
// Testbench for cell_voltage_to_capacity_interp: directed and random pack voltages
`timescale 1ns / 1ps
module cell_voltage_to_capacity_interp_tb;
    import cvci_pkg::*;

    localparam int TABLE_POINTS = 15;
    localparam int VOLT_PTS [TABLE_POINTS] = '{
        2800, 2900, 3000, 3100, 3200, 3300, 3400, 3500,
        3600, 3700, 3800, 3900, 4000, 4100, 4200
    };
    localparam int CAP_PTS [TABLE_POINTS] = '{
        50000, 49600, 48000, 47000, 45000, 43400, 40400, 36000,
        32000, 25400, 18200, 14200, 8000, 3600, 0
    };
    localparam int PACK_MAX = (1 << PACK_W) - 1;
    localparam logic [APB_AW-1:0] ADDR_CELLS = {REG_CELLS, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_RATED = {REG_RATED, 2'b00};
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [CAP_W-1:0]  capacity;
        logic [STAT_W-1:0] status;
    } t_capacity;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cvci_in_if  in_if ();
    cvci_out_if res_if ();

    cell_voltage_to_capacity_interp uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    logic [CELLS_W-1:0] cfg_cells;
    logic [CAP_W-1:0]   cfg_rated;
    t_capacity          expected_caps [$];
    t_capacity          want;
    int                 mismatch_count;
    int                 stall_left;
    int                 cycle_count;
    bit                 steady_mode;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        mismatch_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic t_capacity predict_capacity(input logic [PACK_W-1:0] pack);
        t_capacity r;
        int        divisor;
        int        cell_mv;
        int        val;
        divisor = (cfg_cells == '0) ? 1 : int'(cfg_cells);
        cell_mv = int'(pack) / divisor;
        r.capacity = '0;
        r.status = ST_ABOVE;
        for (int i = 0; i < TABLE_POINTS - 1; i++) begin
            if (cell_mv < VOLT_PTS[i]) begin
                if (i == 0) begin
                    r.capacity = cfg_rated;
                    r.status = ST_BELOW;
                end else begin
                    val = CAP_PTS[i-1] + ((cell_mv - VOLT_PTS[i-1]) * (CAP_PTS[i] - CAP_PTS[i-1]))
                          / (VOLT_PTS[i] - VOLT_PTS[i-1]);
                    r.capacity = CAP_W'(val);
                    r.status = ST_INSIDE;
                end
                break;
            end
        end
        return r;
    endfunction

    function automatic logic [PACK_W-1:0] pick_voltage();
        int unsigned divisor;
        int unsigned cell_mv;
        int unsigned pack;
        int unsigned sel;
        divisor = (cfg_cells == '0) ? 1 : cfg_cells;
        sel = $urandom_range(0, 19);
        if (sel < 2)
            return PACK_W'($urandom);
        else if (sel < 6)
            cell_mv = VOLT_PTS[$urandom_range(0, TABLE_POINTS - 1)] + $urandom_range(0, 2) - 1;
        else
            cell_mv = $urandom_range(2650, 4250);
        pack = cell_mv * divisor + $urandom_range(0, divisor - 1);
        if (pack > PACK_MAX)
            pack = PACK_MAX;
        return PACK_W'(pack);
    endfunction

    task automatic write_reg(input logic [APB_AW-1:0] addr, input int unsigned value);
        logic [APB_DW-1:0] data;
        data = $urandom;
        if (addr == ADDR_CELLS)
            data[CELLS_W-1:0] = value[CELLS_W-1:0];
        else
            data[CAP_W-1:0] = value[CAP_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (addr)
            ADDR_CELLS: cfg_cells = data[CELLS_W-1:0];
            ADDR_RATED: cfg_rated = data[CAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_voltage(input logic [PACK_W-1:0] mv);
        int gap;
        @(negedge i_clk);
        if (!steady_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.pack_voltage_mv <= mv;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_caps.push_back(predict_capacity(mv));
    endtask

    // sender holds off until the pipe is empty
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_caps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned cells, input int unsigned rated);
        wait_drained();
        write_reg(ADDR_CELLS, cells);
        write_reg(ADDR_RATED, rated);
    endtask

    task automatic test_default_table();
        send_voltage('0);
        send_voltage(PACK_W'(2799));
        send_voltage(PACK_W'(2800));
        send_voltage(PACK_W'(2850));
        send_voltage(PACK_W'(3333));
        send_voltage(PACK_W'(3999));
        send_voltage(PACK_W'(4099));
        send_voltage(PACK_W'(4100));
        send_voltage(PACK_W'(4200));
        send_voltage(PACK_W'(PACK_MAX));
    endtask

    task automatic test_register_extremes();
        // zero cells divides by one
        set_config(0, 65535);
        send_voltage(PACK_W'(2799));
        send_voltage(PACK_W'(3456));
        set_config(255, 0);
        send_voltage(PACK_W'(255 * 2800 - 1));
        send_voltage(PACK_W'(255 * 2800));
        send_voltage(PACK_W'(255 * 4100));
        send_voltage(PACK_W'(PACK_MAX));
        set_config(3, 12345);
        send_voltage(PACK_W'(3 * 3750 + 2));
        send_voltage(PACK_W'(3 * 2800 - 1));
    endtask

    task automatic test_random_sweep(input int unsigned cells, input int unsigned rated,
                                     input int count);
        set_config(cells, rated);
        for (int k = 0; k < count; k++)
            send_voltage(pick_voltage());
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!steady_mode && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 17);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_caps.size() == 0) begin
                flag_error("capacity transfer with nothing expected");
            end else begin
                want = expected_caps.pop_front();
                if (res_if.capacity_mah !== want.capacity)
                    flag_error($sformatf("capacity_mah got %0d want %0d",
                                         res_if.capacity_mah, want.capacity));
                if (res_if.range_status !== want.status)
                    flag_error($sformatf("range_status got %0d want %0d",
                                         res_if.range_status, want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int waited;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.pack_voltage_mv = '0;
        res_if.ready = 1'b0;
        mismatch_count = 0;
        stall_left = 0;
        cycle_count = 0;
        steady_mode = 1'b0;
        cfg_cells = CELLS_RST;
        cfg_rated = RATED_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_table();
        test_register_extremes();
        test_random_sweep(1, 50000, 190);
        test_random_sweep(255, 0, 190);
        test_random_sweep(0, 65535, 190);
        test_random_sweep(2, $urandom_range(0, 65535), 190);
        test_random_sweep(14, $urandom_range(0, 65535), 190);
        test_random_sweep($urandom_range(1, 255), $urandom_range(0, 65535), 190);
        test_random_sweep($urandom_range(1, 255), $urandom_range(0, 65535), 190);
        wait_drained();
        steady_mode = 1'b1;
        test_random_sweep(96, $urandom_range(0, 65535), 110);

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        waited = 0;
        while (expected_caps.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_caps.size() != 0)
            flag_error($sformatf("%0d capacity transfers never arrived", expected_caps.size()));
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== cell_voltage_to_capacity_interp.f =====
+incdir+sv
sv/cvci_pkg.sv
sv/cvci_if.sv
sv/cvci_apb.sv
sv/cvci_div.sv
sv/cvci_interp.sv
sv/cell_voltage_to_capacity_interp.sv
tb/cell_voltage_to_capacity_interp_tb.sv
